// ===== hdl/rftk_pkg.sv =====
package rftk_pkg;

    localparam int unsigned ListDepthDefault = 20;
    localparam int unsigned IdWidth          = 8;
    localparam int unsigned RankWidth        = 32;
    localparam int unsigned CoordWidth       = 32;
    localparam int unsigned CfgIndexWidth    = 3;
    localparam int unsigned CfgDataWidth     = 32;
    localparam int unsigned LimitWidth       = 5;
    localparam logic [LimitWidth-1:0] LimitReset = 5'd20;

    typedef enum logic [CfgIndexWidth-1:0] {
        REG_LOW_X  = 3'd0,
        REG_LOW_Y  = 3'd1,
        REG_HIGH_X = 3'd2,
        REG_HIGH_Y = 3'd3,
        REG_LIMIT  = 3'd4
    } t_reg_index;

    typedef struct packed {
        logic signed [IdWidth-1:0]   id;
        logic signed [RankWidth-1:0] rank;
        logic [CoordWidth-1:0]       x;
        logic [CoordWidth-1:0]       y;
    } t_entry;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic insert;    // load a point into the list
        logic clear;     // drop all entries
        logic emit_load; // load the output register from the read index
        logic emit_step; // advance the read index
        logic emit_rst;  // restart the read index
    } t_cmd;

    typedef struct packed {
        logic read_last; // read index is on the final entry
        logic list_empty;
    } t_status;

    // a <= b for IEEE single, false when either is NaN.
    function automatic logic fp_le(input logic [31:0] a, input logic [31:0] b);
        logic a_nan, b_nan, a_zero, b_zero, res;
        a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        a_zero = (a[30:0] == 31'd0);
        b_zero = (b[30:0] == 31'd0);
        if (a_nan || b_nan) begin
            res = 1'b0;
        end else if (a_zero && b_zero) begin
            res = 1'b1;
        end else if (a[31] != b[31]) begin
            res = a[31];
        end else if (a[31]) begin
            res = (a[30:0] >= b[30:0]);
        end else begin
            res = (a[30:0] <= b[30:0]);
        end
        return res;
    endfunction

endpackage

// ===== hdl/rftk_if.sv =====
interface rftk_if #(
    parameter int unsigned Width = 8
);
    logic             valid;
    logic             ready;
    logic [Width-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/rftk_datapath.sv =====
module rftk_datapath #(
    parameter int unsigned ListDepth = rftk_pkg::ListDepthDefault
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  rftk_pkg::t_cmd                      i_cmd,
    input  rftk_pkg::t_entry                    i_point,
    input  logic [rftk_pkg::LimitWidth-1:0]     i_keep_limit,
    output rftk_pkg::t_status                   o_status,
    output rftk_pkg::t_entry                    o_entry,
    output logic                                o_entry_valid,
    output logic                                o_entry_last
);
    import rftk_pkg::*;

    localparam int unsigned IdxW = (ListDepth > 1) ? $clog2(ListDepth) : 1;
    localparam int unsigned CntW = $clog2(ListDepth + 1);

    // Sorted insert chain: every cell compares with the new point at once.
    t_entry             r_list [ListDepth];
    logic [CntW-1:0]    r_fill;
    logic [CntW-1:0]    r_rd;
    t_entry             r_out;
    logic               r_out_valid;
    logic               r_out_last;

    logic [CntW-1:0]    lim;
    logic [CntW-1:0]    n_used;
    logic [ListDepth-1:0] greater;
    logic [ListDepth-1:0] shift_in;
    logic [ListDepth-1:0] take_new;
    logic               accepted;

    always_comb begin
        if (i_keep_limit == '0) begin
            lim = CntW'(1);
        end else if ({{(32-LimitWidth){1'b0}}, i_keep_limit} > ListDepth) begin
            lim = CntW'(ListDepth);
        end else begin
            lim = CntW'(i_keep_limit);
        end
        n_used = (r_fill < lim) ? r_fill : lim;
        for (int i = 0; i < ListDepth; i++) begin
            greater[i] = (CntW'(i) < n_used) && ($signed(i_point.rank) < $signed(r_list[i].rank));
        end
        // Position is the first greater entry, or n_used if none.
        for (int i = 0; i < ListDepth; i++) begin
            if (i == 0) begin
                take_new[i] = greater[i] || (n_used == '0);
                shift_in[i] = 1'b0;
            end else begin
                shift_in[i] = greater[i-1];
                take_new[i] = (greater[i] && !greater[i-1]) ||
                              ((CntW'(i) == n_used) && !greater[i-1]);
            end
        end
        accepted = 1'b0;
        for (int i = 0; i < ListDepth; i++) begin
            if (take_new[i] && (CntW'(i) < lim)) begin
                accepted = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < ListDepth; i++) begin
            if (i_cmd.insert && (CntW'(i) < lim)) begin
                if (take_new[i]) begin
                    r_list[i] <= i_point;
                end else if (shift_in[i] && i > 0) begin
                    r_list[i] <= r_list[(i > 0) ? i - 1 : 0];
                end
            end
        end
        if (i_cmd.emit_load) begin
            if (n_used == '0) begin
                r_out       <= '0;
                r_out_valid <= 1'b0;
                r_out_last  <= 1'b1;
            end else begin
                r_out       <= r_list[r_rd[IdxW-1:0]];
                r_out_valid <= 1'b1;
                r_out_last  <= (r_rd + CntW'(1) >= n_used);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_rd   <= '0;
        end else begin
            if (i_cmd.clear) begin
                r_fill <= '0;
            end else if (i_cmd.insert && accepted) begin
                r_fill <= (n_used < lim) ? n_used + CntW'(1) : lim;
            end
            if (i_cmd.emit_rst) begin
                r_rd <= '0;
            end else if (i_cmd.emit_step) begin
                r_rd <= r_rd + CntW'(1);
            end
        end
    end

    assign o_status.read_last  = (r_rd + CntW'(1) >= n_used);
    assign o_status.list_empty = (n_used == '0);
    assign o_entry       = r_out;
    assign o_entry_valid = r_out_valid;
    assign o_entry_last  = r_out_last;
endmodule

// ===== hdl/rftk_ctrl.sv =====
module rftk_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_last,
    input  logic                i_in_inside,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  rftk_pkg::t_status   i_status,
    output rftk_pkg::t_cmd      o_cmd
);
    import rftk_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_SHOW
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   r_done;
    logic   in_fire;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd = '0;
        o_cmd.insert   = in_fire && i_in_inside;
        o_cmd.emit_rst = in_fire;
        o_cmd.emit_load = (r_state == S_LOAD);
        o_cmd.emit_step = (r_state == S_LOAD);
        o_cmd.clear     = (r_state == S_SHOW) && i_out_ready && r_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_done      <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire && i_in_last) begin
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_out_valid <= 1'b1;
                    r_done      <= i_status.read_last || i_status.list_empty;
                    r_state     <= S_SHOW;
                end
                S_SHOW: begin
                    if (i_out_ready) begin
                        r_out_valid <= 1'b0;
                        r_state     <= r_done ? S_IDLE : S_LOAD;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== hdl/rect_filter_top_k_by_rank.sv =====
// Channel  Direction  Payload
// in       sink       point_id, point_rank, point_x, point_y, point_last
// out      source     out_id, out_rank, out_x, out_y, out_valid, out_last
// A point that does not end a query is taken while idle; the sorted-insert chain
// compares it against all cells in parallel. A last point then emits n beats
// (one if empty), each loaded and then shown until the sink is ready.
// Reset is synchronous and empties the list; the rectangle resets to zero.
// Input is held off while results are emitted.
module rect_filter_top_k_by_rank #(
    parameter int unsigned ListDepth = rftk_pkg::ListDepthDefault
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    rftk_if.sink                                 in_ch,
    rftk_if.source                               out_ch,
    input  logic                                 i_cfg_we,
    input  logic [rftk_pkg::CfgIndexWidth-1:0]   i_cfg_index,
    input  logic [rftk_pkg::CfgDataWidth-1:0]    i_cfg_data
);
    import rftk_pkg::*;

    // in_ch.data = {id, rank, x, y, last}; out_ch.data = {id, rank, x, y, valid, last}
    logic [31:0]           r_low_x, r_low_y, r_high_x, r_high_y;
    logic [LimitWidth-1:0] r_limit;
    t_entry  point;
    logic    last, in_rect;
    t_cmd    cmd;
    t_status status;
    t_entry  entry;
    logic    e_valid, e_last;

    assign point   = in_ch.data[104:1];
    assign last    = in_ch.data[0];
    assign in_rect = fp_le(r_low_x, point.x) && fp_le(point.x, r_high_x) &&
                     fp_le(r_low_y, point.y) && fp_le(point.y, r_high_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_x  <= '0;
            r_low_y  <= '0;
            r_high_x <= '0;
            r_high_y <= '0;
            r_limit  <= LimitReset;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_LOW_X:  r_low_x  <= i_cfg_data;
                REG_LOW_Y:  r_low_y  <= i_cfg_data;
                REG_HIGH_X: r_high_x <= i_cfg_data;
                REG_HIGH_Y: r_high_y <= i_cfg_data;
                REG_LIMIT:  r_limit  <= i_cfg_data[LimitWidth-1:0];
                default: ;
            endcase
        end
    end

    rftk_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_ch.valid),
        .i_in_last   (last),
        .i_in_inside (in_rect),
        .o_in_ready  (in_ch.ready),
        .o_out_valid (out_ch.valid),
        .i_out_ready (out_ch.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    rftk_datapath #(.ListDepth(ListDepth)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_point       (point),
        .i_keep_limit  (r_limit),
        .o_status      (status),
        .o_entry       (entry),
        .o_entry_valid (e_valid),
        .o_entry_last  (e_last)
    );

    assign out_ch.data = {entry, e_valid, e_last};
endmodule

// ===== tb/sv/rect_filter_top_k_by_rank_test.sv =====
module rect_filter_top_k_by_rank_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rftk_pkg::*;

    localparam int unsigned Depth = ListDepthDefault;
    localparam int unsigned InWidth = IdWidth + RankWidth + 2 * CoordWidth + 1;
    localparam int unsigned OutWidth = InWidth + 1;

    localparam logic [31:0] FpZero    = 32'h0000_0000;
    localparam logic [31:0] FpNegZero = 32'h8000_0000;
    localparam logic [31:0] FpOne     = 32'h3F80_0000;
    localparam logic [31:0] FpThree   = 32'h4040_0000;
    localparam logic [31:0] FpTen     = 32'h4120_0000;
    localparam logic [31:0] FpNegTen  = 32'hC120_0000;
    localparam logic [31:0] FpInf     = 32'h7F80_0000;
    localparam logic [31:0] FpNegInf  = 32'hFF80_0000;
    localparam logic [31:0] FpNan     = 32'h7FC0_0000;

    typedef struct packed {
        logic signed [IdWidth-1:0]   id;
        logic signed [RankWidth-1:0] rank;
        logic [CoordWidth-1:0]       x;
        logic [CoordWidth-1:0]       y;
        logic                        hit;
        logic                        last;
    } t_hit;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CfgIndexWidth-1:0] i_cfg_index = '0;
    logic [CfgDataWidth-1:0] i_cfg_data = '0;

    rftk_if #(.Width(InWidth))  point_ch ();
    rftk_if #(.Width(OutWidth)) hit_ch ();

    rect_filter_top_k_by_rank dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .in_ch       (point_ch.sink),
        .out_ch      (hit_ch.source),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Our own copy of the filter state.
    logic [31:0] box_low_x, box_low_y, box_high_x, box_high_y;
    logic [LimitWidth-1:0] keep_count;
    t_entry ranked_list [Depth];
    int unsigned held;
    t_hit expected_hits [$];

    int mismatches = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    always #4 i_clk = ~i_clk;

    initial begin
        point_ch.valid = 1'b0;
        point_ch.data = '0;
        hit_ch.ready = 1'b0;
    end

    function automatic logic is_nan(input logic [31:0] a);
        return (a[30:23] == 8'hFF) && (a[22:0] != 0);
    endfunction

    // Orders IEEE bit patterns by mapping them onto an unsigned key line.
    function automatic logic coord_le(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] ka, kb;
        if (is_nan(a) || is_nan(b)) return 1'b0;
        if (a[30:0] == 0 && b[30:0] == 0) return 1'b1;
        ka = a[31] ? ~a : (a | 32'h8000_0000);
        kb = b[31] ? ~b : (b | 32'h8000_0000);
        return ka <= kb;
    endfunction

    function automatic int unsigned live_limit();
        if (keep_count < 1) return 1;
        if (keep_count > Depth) return Depth;
        return keep_count;
    endfunction

    function automatic void predict_point(input logic [InWidth-1:0] beat);
        t_entry p;
        logic last;
        int unsigned lim, n, pos, newn;
        t_hit h;
        {p.id, p.rank, p.x, p.y, last} = beat;
        lim = live_limit();
        if (coord_le(box_low_x, p.x) && coord_le(p.x, box_high_x) &&
            coord_le(box_low_y, p.y) && coord_le(p.y, box_high_y)) begin
            n = (held < lim) ? held : lim;
            pos = n;
            for (int i = n - 1; i >= 0; i--) begin
                if (p.rank < ranked_list[i].rank) pos = i;
            end
            if (pos < lim) begin
                newn = (n < lim) ? n + 1 : lim;
                for (int i = newn - 1; i > int'(pos); i--) ranked_list[i] = ranked_list[i-1];
                ranked_list[pos] = p;
                held = newn;
            end
        end
        if (!last) return;
        n = (held < lim) ? held : lim;
        held = 0;
        if (n == 0) begin
            h = '0;
            h.last = 1'b1;
            expected_hits.push_back(h);
        end
        for (int k = 0; k < int'(n); k++) begin
            h.id = ranked_list[k].id;
            h.rank = ranked_list[k].rank;
            h.x = ranked_list[k].x;
            h.y = ranked_list[k].y;
            h.hit = 1'b1;
            h.last = (k + 1 == int'(n));
            expected_hits.push_back(h);
        end
    endfunction

    always @(posedge i_clk) begin
        hit_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_hit got, want;
        if (i_rst_n && hit_ch.valid && hit_ch.ready) begin
            got = hit_ch.data;
            if (expected_hits.size() == 0) begin
                $error("unexpected result beat %h", got);
                mismatches++;
            end else begin
                want = expected_hits.pop_front();
                if (got.id !== want.id) begin
                    $error("out_id expected %0d actual %0d", want.id, got.id);
                    mismatches++;
                end
                if (got.rank !== want.rank) begin
                    $error("out_rank expected %0d actual %0d", want.rank, got.rank);
                    mismatches++;
                end
                if (got.x !== want.x) begin
                    $error("out_x expected %h actual %h", want.x, got.x);
                    mismatches++;
                end
                if (got.y !== want.y) begin
                    $error("out_y expected %h actual %h", want.y, got.y);
                    mismatches++;
                end
                if (got.hit !== want.hit) begin
                    $error("out_valid expected %0b actual %0b", want.hit, got.hit);
                    mismatches++;
                end
                if (got.last !== want.last) begin
                    $error("out_last expected %0b actual %0b", want.last, got.last);
                    mismatches++;
                end
            end
        end
    end

    task automatic send_point(input logic signed [7:0] id, input logic signed [31:0] rank,
                              input logic [31:0] x, input logic [31:0] y, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            point_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        point_ch.valid <= 1'b1;
        point_ch.data <= {id, rank, x, y, last};
        do @(posedge i_clk); while (!point_ch.ready);
        predict_point({id, rank, x, y, last});
    endtask

    task automatic drain_results();
        point_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_hits.size() != 0) @(posedge i_clk);
        // The last beat of a query may still be leaving the output stage.
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_index idx, input logic [31:0] value);
        drain_results();
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        unique case (idx)
            REG_LOW_X:  box_low_x = value;
            REG_LOW_Y:  box_low_y = value;
            REG_HIGH_X: box_high_x = value;
            REG_HIGH_Y: box_high_y = value;
            REG_LIMIT:  keep_count = value[LimitWidth-1:0];
            default: ;
        endcase
    endtask

    task automatic set_box(input logic [31:0] lx, input logic [31:0] ly,
                           input logic [31:0] hx, input logic [31:0] hy);
        write_reg(REG_LOW_X, lx);
        write_reg(REG_LOW_Y, ly);
        write_reg(REG_HIGH_X, hx);
        write_reg(REG_HIGH_Y, hy);
    endtask

    task automatic test_reset_box();
        // Zero box: only zeros of either sign pass.
        send_point(8'sd1, 32'sd5, FpZero, FpNegZero, 1'b0);
        send_point(8'sd2, 32'sd4, FpOne, FpZero, 1'b0);
        send_point(8'sd3, 32'sd3, FpNan, FpZero, 1'b1);
        send_point(8'sd4, 32'sd0, FpOne, FpOne, 1'b1);
    endtask

    task automatic test_boundaries();
        set_box(FpNegTen, FpNegTen, FpTen, FpTen);
        send_point(-8'sd128, 32'sh7FFF_FFFF, FpTen, FpNegTen, 1'b0);
        send_point(8'sd127, -32'sh8000_0000, FpNegTen, FpTen, 1'b0);
        send_point(8'sd5, 32'sd0, 32'h4120_0001, FpZero, 1'b0);
        send_point(8'sd6, 32'sd0, FpZero, FpNan, 1'b0);
        send_point(8'sd7, 32'sd0, FpInf, FpZero, 1'b0);
        send_point(8'sd8, 32'sd0, FpNegInf, FpZero, 1'b0);
        send_point(8'sd9, 32'sd0, 32'hFFFF_FFFF, FpZero, 1'b0);
        send_point(8'sd10, 32'sd0, FpThree, FpNegZero, 1'b1);
    endtask

    task automatic test_ties_and_limit();
        write_reg(REG_LIMIT, 32'd3);
        send_point(8'sd11, 32'sd2, FpOne, FpOne, 1'b0);
        send_point(8'sd12, 32'sd2, FpOne, FpOne, 1'b0);
        send_point(8'sd13, 32'sd1, FpOne, FpOne, 1'b0);
        send_point(8'sd14, 32'sd2, FpOne, FpOne, 1'b0);
        send_point(8'sd15, -32'sd1, FpOne, FpOne, 1'b1);
        // Maximum rank still fills a free slot, then is dropped once full.
        send_point(8'sd16, 32'sh7FFF_FFFF, FpOne, FpOne, 1'b0);
        send_point(8'sd17, 32'sd0, FpOne, FpOne, 1'b0);
        send_point(8'sd18, 32'sd0, FpOne, FpOne, 1'b0);
        send_point(8'sd19, 32'sh7FFF_FFFF, FpOne, FpOne, 1'b1);
        write_reg(REG_LIMIT, 32'd0);
        send_point(8'sd20, 32'sd9, FpOne, FpOne, 1'b0);
        send_point(8'sd21, 32'sd8, FpOne, FpOne, 1'b1);
        write_reg(REG_LIMIT, 32'd31);
        for (int i = 0; i < 22; i++)
            send_point(i[7:0], 32'(21 - i), FpOne, FpThree, i == 21);
        // Fill under a large limit, then lower it before the query ends.
        for (int i = 0; i < 6; i++) send_point(i[7:0], 32'(i), FpOne, FpOne, 1'b0);
        write_reg(REG_LIMIT, 32'd2);
        send_point(8'sd30, 32'sd3, FpOne, FpOne, 1'b1);
        write_reg(REG_LIMIT, 32'd20);
    endtask

    function automatic logic [31:0] pick_coord();
        logic [31:0] pool [12] = '{FpZero, FpNegZero, FpOne, 32'hBF80_0000, FpThree,
                                  32'hC040_0000, FpTen, FpNegTen, 32'h41A0_0000,
                                  FpInf, FpNegInf, 32'h0000_0001};
        unique case ($urandom_range(9))
            0: return $urandom();
            1: return {1'($urandom_range(1)), 8'hFF, 23'($urandom_range(1, 32'h7F_FFFF))};
            default: return pool[$urandom_range(11)];
        endcase
    endfunction

    function automatic logic [31:0] pick_rank();
        unique case ($urandom_range(7))
            0: return $urandom();
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0000;
            default: return 32'($urandom_range(12)) - 32'd4;
        endcase
    endfunction

    task automatic run_queries(input int points);
        int sent = 0;
        int len;
        while (sent < points) begin
            len = $urandom_range(24);
            if (len > points - sent - 1) len = points - sent - 1;
            for (int i = 0; i <= len; i++) begin
                send_point(8'($urandom()), pick_rank(), pick_coord(), pick_coord(), i == len);
                sent++;
            end
        end
    endtask

    task automatic test_random();
        set_box(FpNegTen, FpNegTen, FpTen, FpTen);
        write_reg(REG_LIMIT, 32'd1 + 32'($urandom_range(19)));
        send_idle_pct = 33;
        recv_stall_pct = 46;
        run_queries(23);
        set_box(FpNegInf, 32'hC040_0000, FpInf, FpTen);
        write_reg(REG_LIMIT, 32'd20);
        send_idle_pct = 46;
        recv_stall_pct = 33;
        run_queries(23);
        set_box(pick_coord(), pick_coord(), pick_coord(), pick_coord());
        write_reg(REG_LIMIT, 32'($urandom_range(31)));
        send_idle_pct = 0;
        recv_stall_pct = 0;
        run_queries(23);
    endtask

    initial begin
        box_low_x = FpZero;
        box_low_y = FpZero;
        box_high_x = FpZero;
        box_high_y = FpZero;
        keep_count = LimitReset;
        held = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_idle_pct = 20;
        recv_stall_pct = 30;
        test_reset_box();
        test_boundaries();
        test_ties_and_limit();
        test_random();
        drain_results();
        repeat (50) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/rftk_pkg.sv
hdl/rftk_if.sv
hdl/rftk_datapath.sv
hdl/rftk_ctrl.sv
hdl/rect_filter_top_k_by_rank.sv
tb/sv/rect_filter_top_k_by_rank_test.sv
